// ===== design/sgc_pkg.sv =====
`default_nettype none

package sgc_pkg;

  // Frequency format: Q1.16, one is 2^16
  localparam int FREQ_BITS = 16;
  localparam int FREQ_W    = FREQ_BITS + 1;
  localparam int SUM_W     = 48;
  localparam int CNT16_W   = 16;
  localparam int CNT24_W   = 24;
  localparam int DIV_W     = 2 * FREQ_BITS;       // 2f(1-f), below 2^32
  localparam int DVG_W     = 2 * FREQ_BITS + 1;   // fx(1-fy)+fy(1-fx), up to 2^32

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << FREQ_BITS;

  // Threshold reset values
  localparam logic [FREQ_W-1:0] STRONG_RESET = 17'd62259;
  localparam logic [FREQ_W-1:0] WEAK_RESET   = 17'd52429;

  // Configuration register indexes
  localparam logic CFG_STRONG = 1'b0;
  localparam logic CFG_WEAK   = 1'b1;

  // Request codes
  localparam logic [1:0] REQ_POLY = 2'd0;
  localparam logic [1:0] REQ_PAIR = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  // Characters
  localparam logic [7:0] CH_N_UP  = 8'h4E;  // 'N'
  localparam logic [7:0] CH_N_LOW = 8'h6E;  // 'n'
  localparam logic [7:0] CH_X     = 8'h58;  // 'X'
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [2:0] {
    BC_UNK,
    BC_A,
    BC_C,
    BC_G,
    BC_T,
    BC_BAD
  } base_code_t;

  typedef enum logic [1:0] {
    MK_POLY,
    MK_PLAIN,
    MK_STATS
  } mid_kind_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FREQ_W-1:0] freq_first;
    logic [FREQ_W-1:0] freq_second;
    logic [7:0]        allele_one;
    logic [7:0]        allele_two;
    logic [7:0]        base_left;
    logic [7:0]        base_right;
    logic              last_pair;
  } in_t;

  typedef struct packed {
    logic [7:0]         x_char;
    logic [7:0]         y_char;
    logic               char_valid;
    logic               stats_valid;
    logic [CNT16_W-1:0] poly_count;
    logic [CNT16_W-1:0] fixed_count;
    logic [CNT24_W-1:0] called_count;
    logic [CNT24_W-1:0] site_count;
    logic [SUM_W-1:0]   div_x_sum;
    logic [SUM_W-1:0]   div_y_sum;
    logic [SUM_W-1:0]   divergence_sum;
    logic               bad_base;
  } out_t;

  // Work handed from the call stage to the accumulate stage
  typedef struct packed {
    mid_kind_t        kind;
    logic [7:0]       x_char;
    logic [7:0]       y_char;
    logic             bad_base;
    logic             called;
    logic             fixed_diff;
    logic [DIV_W-1:0] div_x;
    logic [DIV_W-1:0] div_y;
    logic [DVG_W-1:0] dvg;
  } mid_t;

endpackage

`default_nettype wire

// ===== design/sgc_front.sv =====
`default_nettype none

module sgc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sgc_pkg::in_t                  in_data,
  input  wire logic [sgc_pkg::FREQ_W-1:0]    strong_thr,
  input  wire logic [sgc_pkg::FREQ_W-1:0]    weak_thr,
  input  wire logic                          mid_free,
  output logic                               mid_valid,
  output sgc_pkg::mid_t                      mid_data
);

  localparam int FW = sgc_pkg::FREQ_W;
  localparam int PW = 2 * FW;

  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    up_ascii = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] low_ascii(input logic [7:0] c);
    low_ascii = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // f <= ONE - t, never true when t is above one
  function automatic logic below_mirror(input logic [FW-1:0] f, input logic [FW-1:0] t);
    logic [FW:0] s;
    s = {1'b0, f} + {1'b0, t};
    below_mirror = (t <= sgc_pkg::FREQ_ONE) && (s <= {1'b0, sgc_pkg::FREQ_ONE});
  endfunction

  function automatic sgc_pkg::base_code_t base_code(input logic [7:0] c);
    case (c)
      8'h61, 8'h41: base_code = sgc_pkg::BC_A;
      8'h63, 8'h43: base_code = sgc_pkg::BC_C;
      8'h67, 8'h47: base_code = sgc_pkg::BC_G;
      8'h74, 8'h54: base_code = sgc_pkg::BC_T;
      8'h2E, 8'h6E, 8'h4E: base_code = sgc_pkg::BC_UNK;
      default: base_code = sgc_pkg::BC_BAD;
    endcase
  endfunction

  function automatic logic [3:0] base_bit(input sgc_pkg::base_code_t c);
    case (c)
      sgc_pkg::BC_A: base_bit = 4'b0001;
      sgc_pkg::BC_C: base_bit = 4'b0010;
      sgc_pkg::BC_G: base_bit = 4'b0100;
      sgc_pkg::BC_T: base_bit = 4'b1000;
      default: base_bit = 4'b0000;
    endcase
  endfunction

  logic            s1_valid_r, s1_valid_nxt;
  sgc_pkg::in_t    s1_data_r;
  logic            s1_go, fwd, in_xfer;
  logic            mid_valid_r;
  sgc_pkg::mid_t   mid_data_r, mid_nxt;
  logic [3:0]      pres_r, pres_nxt, pres_cur;
  logic            bad_r, bad_nxt, bad_cur;
  sgc_pkg::base_code_t code_l, code_r;
  logic [FW-1:0]   fx, fy, omx, omy;
  logic [PW-1:0]   px, py, pxy, dvg_full;
  logic [7:0]      x_ch, y_ch, plain_ch;
  logic            fixed_diff;

  // Items that produce a result move on to the next stage
  assign fwd = (s1_data_r.req_type == sgc_pkg::REQ_POLY) ||
               (s1_data_r.req_type == sgc_pkg::REQ_END) ||
               ((s1_data_r.req_type == sgc_pkg::REQ_PAIR) && s1_data_r.last_pair);
  assign s1_go    = s1_valid_r && (!fwd || mid_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  // Clamp frequencies to one
  assign fx  = (s1_data_r.freq_first > sgc_pkg::FREQ_ONE) ? sgc_pkg::FREQ_ONE
                                                           : s1_data_r.freq_first;
  assign fy  = (s1_data_r.freq_second > sgc_pkg::FREQ_ONE) ? sgc_pkg::FREQ_ONE
                                                            : s1_data_r.freq_second;
  assign omx = sgc_pkg::FREQ_ONE - fx;
  assign omy = sgc_pkg::FREQ_ONE - fy;

  // Diversity and divergence products; divergence is ONE*(fx+fy) - 2*fx*fy
  assign px       = PW'(fx) * PW'(omx);
  assign py       = PW'(fy) * PW'(omy);
  assign pxy      = PW'(fx) * PW'(fy);
  assign dvg_full = ((PW'(fx) + PW'(fy)) << sgc_pkg::FREQ_BITS) - (pxy << 1);

  // Call characters for each copy
  always_comb begin
    if (fx >= strong_thr) begin
      x_ch = up_ascii(s1_data_r.allele_one);
    end else if (fx >= weak_thr) begin
      x_ch = low_ascii(s1_data_r.allele_one);
    end else if (below_mirror(fx, strong_thr)) begin
      x_ch = up_ascii(s1_data_r.allele_two);
    end else if (below_mirror(fx, weak_thr)) begin
      x_ch = low_ascii(s1_data_r.allele_two);
    end else begin
      x_ch = sgc_pkg::CH_N_LOW;
    end
    if (fy >= strong_thr) begin
      y_ch = up_ascii(s1_data_r.allele_one);
    end else if (fy >= weak_thr) begin
      y_ch = low_ascii(s1_data_r.allele_one);
    end else if (below_mirror(fy, strong_thr)) begin
      y_ch = up_ascii(s1_data_r.allele_two);
    end else if (below_mirror(fy, weak_thr)) begin
      y_ch = low_ascii(s1_data_r.allele_two);
    end else begin
      y_ch = sgc_pkg::CH_N_LOW;
    end
  end

  assign fixed_diff = ((fx >= strong_thr) && below_mirror(fy, strong_thr)) ||
                      ((fy >= strong_thr) && below_mirror(fx, strong_thr));

  // Plain-site tally including the current pair
  assign code_l   = base_code(s1_data_r.base_left);
  assign code_r   = base_code(s1_data_r.base_right);
  assign pres_cur = pres_r | base_bit(code_l) | base_bit(code_r);
  assign bad_cur  = bad_r || (code_l == sgc_pkg::BC_BAD) || (code_r == sgc_pkg::BC_BAD);

  always_comb begin
    plain_ch = sgc_pkg::CH_N_UP;
    if (!bad_cur && (pres_cur != 4'b0000)) begin
      if (!$onehot(pres_cur)) begin
        plain_ch = sgc_pkg::CH_X;
      end else if (pres_cur[0]) begin
        plain_ch = sgc_pkg::CH_A;
      end else if (pres_cur[1]) begin
        plain_ch = sgc_pkg::CH_C;
      end else if (pres_cur[2]) begin
        plain_ch = sgc_pkg::CH_G;
      end else begin
        plain_ch = sgc_pkg::CH_T;
      end
    end
  end

  // Advance or clear the tally as items leave the input register
  always_comb begin
    pres_nxt = pres_r;
    bad_nxt  = bad_r;
    if (s1_go) begin
      case (s1_data_r.req_type)
        sgc_pkg::REQ_POLY, sgc_pkg::REQ_END: begin
          pres_nxt = 4'b0000;
          bad_nxt  = 1'b0;
        end
        sgc_pkg::REQ_PAIR: begin
          if (s1_data_r.last_pair) begin
            pres_nxt = 4'b0000;
            bad_nxt  = 1'b0;
          end else begin
            pres_nxt = pres_cur;
            bad_nxt  = bad_cur;
          end
        end
        default: begin
          pres_nxt = pres_r;
          bad_nxt  = bad_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= 4'b0000;
      bad_r  <= 1'b0;
    end else begin
      pres_r <= pres_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // Build the work for the accumulate stage
  always_comb begin
    mid_nxt            = '0;
    mid_nxt.div_x      = {px[sgc_pkg::DIV_W-2:0], 1'b0};
    mid_nxt.div_y      = {py[sgc_pkg::DIV_W-2:0], 1'b0};
    mid_nxt.dvg        = dvg_full[sgc_pkg::DVG_W-1:0];
    mid_nxt.fixed_diff = fixed_diff;
    case (s1_data_r.req_type)
      sgc_pkg::REQ_POLY: begin
        mid_nxt.kind   = sgc_pkg::MK_POLY;
        mid_nxt.x_char = x_ch;
        mid_nxt.y_char = y_ch;
      end
      sgc_pkg::REQ_PAIR: begin
        mid_nxt.kind     = sgc_pkg::MK_PLAIN;
        mid_nxt.x_char   = plain_ch;
        mid_nxt.y_char   = plain_ch;
        mid_nxt.bad_base = bad_cur;
        mid_nxt.called   = !bad_cur && (pres_cur != 4'b0000);
      end
      default: begin
        mid_nxt.kind = sgc_pkg::MK_STATS;
      end
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (mid_free) begin
      mid_valid_r <= s1_go && fwd;
    end
    if (mid_free && s1_go && fwd) begin
      mid_data_r <= mid_nxt;
    end
  end

  assign mid_valid = mid_valid_r;
  assign mid_data  = mid_data_r;

endmodule

`default_nettype wire

// ===== design/sgc_accum.sv =====
`default_nettype none

module sgc_accum (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           mid_valid,
  input  wire sgc_pkg::mid_t  mid_data,
  output logic                mid_free,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sgc_pkg::out_t       out_data
);

  localparam int SW  = sgc_pkg::SUM_W;
  localparam int C16 = sgc_pkg::CNT16_W;
  localparam int C24 = sgc_pkg::CNT24_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
                                             input logic [SW-1:0] v);
    logic [SW:0] s;
    s = {1'b0, acc} + {1'b0, v};
    sat_add = s[SW] ? '1 : s[SW-1:0];
  endfunction

  function automatic logic [C16-1:0] inc16(input logic [C16-1:0] c);
    inc16 = (c == '1) ? c : c + C16'(1);
  endfunction

  function automatic logic [C24-1:0] inc24(input logic [C24-1:0] c);
    inc24 = (c == '1) ? c : c + C24'(1);
  endfunction

  logic            out_free, mid_go;
  logic            o_valid_r;
  sgc_pkg::out_t   o_data_r, o_nxt;
  logic [C16-1:0]  poly_r, poly_nxt, fixed_r, fixed_nxt;
  logic [C24-1:0]  called_r, called_nxt, site_r, site_nxt;
  logic [SW-1:0]   dx_r, dx_nxt, dy_r, dy_nxt, dvg_r, dvg_nxt;

  // Every item here produces a result, so it moves only into a free output slot
  assign out_free = !o_valid_r || !out_stall;
  assign mid_go   = mid_valid && out_free;
  assign mid_free = !mid_valid || out_free;

  // Accumulate and build the result
  always_comb begin
    poly_nxt   = poly_r;
    fixed_nxt  = fixed_r;
    called_nxt = called_r;
    site_nxt   = site_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dvg_nxt    = dvg_r;
    o_nxt      = '0;
    case (mid_data.kind)
      sgc_pkg::MK_POLY: begin
        dx_nxt     = sat_add(dx_r, SW'(mid_data.div_x));
        dy_nxt     = sat_add(dy_r, SW'(mid_data.div_y));
        dvg_nxt    = sat_add(dvg_r, SW'(mid_data.dvg));
        fixed_nxt  = mid_data.fixed_diff ? inc16(fixed_r) : fixed_r;
        poly_nxt   = inc16(poly_r);
        called_nxt = inc24(called_r);
        site_nxt   = inc24(site_r);
        o_nxt.x_char     = mid_data.x_char;
        o_nxt.y_char     = mid_data.y_char;
        o_nxt.char_valid = 1'b1;
      end
      sgc_pkg::MK_PLAIN: begin
        called_nxt = mid_data.called ? inc24(called_r) : called_r;
        site_nxt   = inc24(site_r);
        o_nxt.x_char     = mid_data.x_char;
        o_nxt.y_char     = mid_data.y_char;
        o_nxt.char_valid = 1'b1;
        o_nxt.bad_base   = mid_data.bad_base;
      end
      default: begin
        o_nxt.stats_valid    = 1'b1;
        o_nxt.poly_count     = poly_r;
        o_nxt.fixed_count    = fixed_r;
        o_nxt.called_count   = called_r;
        o_nxt.site_count     = site_r;
        o_nxt.div_x_sum      = dx_r;
        o_nxt.div_y_sum      = dy_r;
        o_nxt.divergence_sum = dvg_r;
        poly_nxt   = '0;
        fixed_nxt  = '0;
        called_nxt = '0;
        site_nxt   = '0;
        dx_nxt     = '0;
        dy_nxt     = '0;
        dvg_nxt    = '0;
      end
    endcase
  end

  // Contig counters and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= '0;
      fixed_r  <= '0;
      called_r <= '0;
      site_r   <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      dvg_r    <= '0;
    end else if (mid_go) begin
      poly_r   <= poly_nxt;
      fixed_r  <= fixed_nxt;
      called_r <= called_nxt;
      site_r   <= site_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      dvg_r    <= dvg_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (out_free) begin
      o_valid_r <= mid_go;
    end
    if (mid_go) begin
      o_data_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_data_r.char_valid ^ o_data_r.stats_valid))
    else $error("result carries both or neither of characters and statistics");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && out_stall) |-> !mid_go)
    else $error("accumulate stage advanced into a held result");

  a_stats_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_go && mid_data.kind == sgc_pkg::MK_STATS) |=>
      (poly_r == '0 && site_r == '0 && dx_r == '0 && dvg_r == '0))
    else $error("counters not cleared after statistics report");

  a_called_le_site: assert property (@(posedge clk) disable iff (!rst_n)
    called_r <= site_r)
    else $error("called site count exceeds site count");

endmodule

`default_nettype wire

// ===== design/site_genotype_caller.sv =====
`default_nettype none

// Per-site caller for the two sex-linked copies of one contig. Each transfer on
// the input channel is a polymorphic site, one genotype pair of a plain site, or
// an end-of-contig marker; sites and the last pair of a plain site return one
// character result, end of contig returns the saturated counters and Q16.32 sums
// and clears them. The block takes one item per cycle while the output is not stalled. An
// item passes an input register, a register after the frequency multipliers (three
// 17x17 products per site), and the result register behind the 48-bit saturating
// accumulators. The user must write thresholds through the cfg port only while no item
// is in flight; the block itself does not enforce this.
module site_genotype_caller (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire sgc_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output sgc_pkg::out_t                    out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [sgc_pkg::FREQ_W-1:0]  cfg_data
);

  logic [sgc_pkg::FREQ_W-1:0] strong_r, weak_r;
  logic                       mid_valid, mid_free;
  sgc_pkg::mid_t              mid_data;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strong_r <= sgc_pkg::STRONG_RESET;
      weak_r   <= sgc_pkg::WEAK_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgc_pkg::CFG_STRONG: strong_r <= cfg_data;
        sgc_pkg::CFG_WEAK:   weak_r   <= cfg_data;
        default: strong_r <= strong_r;
      endcase
    end
  end

  sgc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .strong_thr (strong_r),
    .weak_thr   (weak_r),
    .mid_free   (mid_free),
    .mid_valid  (mid_valid),
    .mid_data   (mid_data)
  );

  sgc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_data  (mid_data),
    .mid_free  (mid_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_NONE    = 2'd3;
  localparam logic [16:0] FREQ_MAX    = 17'h1FFFF;
  localparam logic [16:0] FREQ_HALF   = 17'h08000;
  localparam logic [63:0] ONE_WIDE    = 64'd1 << sgc_pkg::FREQ_BITS;
  localparam logic [63:0] SUM_LIMIT   = (64'd1 << sgc_pkg::SUM_W) - 1;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          SETTLE_CYC  = 16;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  sgc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sgc_pkg::out_t out_data;
  logic          cfg_wr_en = 1'b0;
  logic          cfg_index = 1'b0;
  logic [sgc_pkg::FREQ_W-1:0] cfg_data = '0;

  // Items waiting for a transfer, and calls still owed by the block
  sgc_pkg::in_t  site_feed [$];
  sgc_pkg::out_t calls_due [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // Caller state as the block should hold it
  logic [16:0] thr_strong = sgc_pkg::STRONG_RESET;
  logic [16:0] thr_weak = sgc_pkg::WEAK_RESET;
  logic [15:0] poly_tot = '0;
  logic [15:0] fixed_tot = '0;
  logic [23:0] called_tot = '0;
  logic [23:0] site_tot = '0;
  logic [47:0] div_x_acc = '0;
  logic [47:0] div_y_acc = '0;
  logic [47:0] dvg_acc = '0;
  logic [7:0]  base_seen [5] = '{default: '0};
  logic        site_flag = 1'b0;

  site_genotype_caller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10ns clk = ~clk;

  function automatic logic [16:0] clamp_freq(logic [16:0] f);
    return (f > sgc_pkg::FREQ_ONE) ? sgc_pkg::FREQ_ONE : f;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // f <= ONE - t, where a threshold above one leaves no room at all
  function automatic bit under_mirror(logic [16:0] f, logic [16:0] t);
    return t <= sgc_pkg::FREQ_ONE && f <= sgc_pkg::FREQ_ONE - t;
  endfunction

  function automatic logic [7:0] pick_char(logic [16:0] f, logic [7:0] a1, logic [7:0] a2);
    if (f >= thr_strong) return to_upper(a1);
    if (f >= thr_weak) return to_lower(a1);
    if (under_mirror(f, thr_strong)) return to_upper(a2);
    if (under_mirror(f, thr_weak)) return to_lower(a2);
    return sgc_pkg::CH_N_LOW;
  endfunction

  function automatic logic [47:0] sum_sat(logic [47:0] acc, logic [63:0] v);
    logic [63:0] t;
    t = acc + v;
    return (t > SUM_LIMIT) ? SUM_LIMIT[47:0] : t[47:0];
  endfunction

  function automatic sgc_pkg::base_code_t base_class(logic [7:0] c);
    case (c)
      "A", "a": return sgc_pkg::BC_A;
      "C", "c": return sgc_pkg::BC_C;
      "G", "g": return sgc_pkg::BC_G;
      "T", "t": return sgc_pkg::BC_T;
      ".", "N", "n": return sgc_pkg::BC_UNK;
      default: return sgc_pkg::BC_BAD;
    endcase
  endfunction

  function automatic void clear_site();
    for (int k = 0; k < 5; k++) base_seen[k] = '0;
    site_flag = 1'b0;
  endfunction

  function automatic void tally_base(logic [7:0] c);
    sgc_pkg::base_code_t k;
    k = base_class(c);
    if (k == sgc_pkg::BC_BAD) site_flag = 1'b1;
    else if (base_seen[k] != 8'hFF) base_seen[k]++;
  endfunction

  // Advance the caller state by one transfer; return 1 when a call results
  function automatic bit predict_call(input sgc_pkg::in_t d, output sgc_pkg::out_t r);
    logic [16:0]         fx, fy;
    logic [63:0]         wx, wy;
    logic [7:0]          ch;
    int                  kinds;
    sgc_pkg::base_code_t first;
    r = '0;
    case (d.req_type)
      sgc_pkg::REQ_POLY: begin
        fx = clamp_freq(d.freq_first);
        fy = clamp_freq(d.freq_second);
        wx = fx;
        wy = fy;
        clear_site();
        r.x_char = pick_char(fx, d.allele_one, d.allele_two);
        r.y_char = pick_char(fy, d.allele_one, d.allele_two);
        r.char_valid = 1'b1;
        div_x_acc = sum_sat(div_x_acc, 2 * wx * (ONE_WIDE - wx));
        div_y_acc = sum_sat(div_y_acc, 2 * wy * (ONE_WIDE - wy));
        dvg_acc = sum_sat(dvg_acc, wx * (ONE_WIDE - wy) + wy * (ONE_WIDE - wx));
        if ((fx >= thr_strong && under_mirror(fy, thr_strong)) ||
            (fy >= thr_strong && under_mirror(fx, thr_strong))) begin
          if (fixed_tot != '1) fixed_tot++;
        end
        if (poly_tot != '1) poly_tot++;
        if (called_tot != '1) called_tot++;
        if (site_tot != '1) site_tot++;
        return 1'b1;
      end
      sgc_pkg::REQ_PAIR: begin
        tally_base(d.base_left);
        tally_base(d.base_right);
        if (!d.last_pair) return 1'b0;
        kinds = 0;
        first = sgc_pkg::BC_UNK;
        for (int k = sgc_pkg::BC_A; k <= sgc_pkg::BC_T; k++) begin
          if (base_seen[k] != 0) begin
            kinds++;
            if (first == sgc_pkg::BC_UNK) first = sgc_pkg::base_code_t'(k);
          end
        end
        ch = sgc_pkg::CH_N_UP;
        if (!site_flag && kinds > 0) begin
          if (kinds > 1) ch = sgc_pkg::CH_X;
          else begin
            case (first)
              sgc_pkg::BC_A: ch = sgc_pkg::CH_A;
              sgc_pkg::BC_C: ch = sgc_pkg::CH_C;
              sgc_pkg::BC_G: ch = sgc_pkg::CH_G;
              default: ch = sgc_pkg::CH_T;
            endcase
          end
          if (called_tot != '1) called_tot++;
        end
        if (site_tot != '1) site_tot++;
        r.x_char = ch;
        r.y_char = ch;
        r.char_valid = 1'b1;
        r.bad_base = site_flag;
        clear_site();
        return 1'b1;
      end
      sgc_pkg::REQ_END: begin
        clear_site();
        r.stats_valid = 1'b1;
        r.poly_count = poly_tot;
        r.fixed_count = fixed_tot;
        r.called_count = called_tot;
        r.site_count = site_tot;
        r.div_x_sum = div_x_acc;
        r.div_y_sum = div_y_acc;
        r.divergence_sum = dvg_acc;
        poly_tot = '0;
        fixed_tot = '0;
        called_tot = '0;
        site_tot = '0;
        div_x_acc = '0;
        div_y_acc = '0;
        dvg_acc = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string show_result(sgc_pkg::out_t r);
    return $sformatf({"x=%h y=%h cv=%b sv=%b poly=%0d fixed=%0d called=%0d sites=%0d",
                      " dx=%h dy=%h dv=%h bad=%b"},
                     r.x_char, r.y_char, r.char_valid, r.stats_valid, r.poly_count,
                     r.fixed_count, r.called_count, r.site_count, r.div_x_sum,
                     r.div_y_sum, r.divergence_sum, r.bad_base);
  endfunction

  // Fill every field at random; callers overwrite what matters
  function automatic sgc_pkg::in_t noise_item();
    sgc_pkg::in_t d;
    d.req_type = 2'($urandom_range(0, 3));
    d.freq_first = 17'($urandom_range(0, FREQ_MAX));
    d.freq_second = 17'($urandom_range(0, FREQ_MAX));
    d.allele_one = 8'($urandom_range(0, 255));
    d.allele_two = 8'($urandom_range(0, 255));
    d.base_left = 8'($urandom_range(0, 255));
    d.base_right = 8'($urandom_range(0, 255));
    d.last_pair = 1'($urandom_range(0, 1));
    return d;
  endfunction

  function automatic void push_poly(logic [16:0] f1, logic [16:0] f2,
                                    logic [7:0] a1, logic [7:0] a2);
    sgc_pkg::in_t d;
    d = noise_item();
    d.req_type = sgc_pkg::REQ_POLY;
    d.freq_first = f1;
    d.freq_second = f2;
    d.allele_one = a1;
    d.allele_two = a2;
    site_feed.push_back(d);
  endfunction

  function automatic void push_pair(logic [7:0] b1, logic [7:0] b2, bit last);
    sgc_pkg::in_t d;
    d = noise_item();
    d.req_type = sgc_pkg::REQ_PAIR;
    d.base_left = b1;
    d.base_right = b2;
    d.last_pair = last;
    site_feed.push_back(d);
  endfunction

  function automatic void push_kind(logic [1:0] req);
    sgc_pkg::in_t d;
    d = noise_item();
    d.req_type = req;
    site_feed.push_back(d);
  endfunction

  // Frequencies cluster on the thresholds, their mirrors and the extremes, or are drawn at random
  function automatic logic [16:0] pick_freq();
    case ($urandom_range(0, 7))
      0: return 17'(thr_strong - 1 + $urandom_range(0, 2));
      1: return 17'(thr_weak - 1 + $urandom_range(0, 2));
      2: return 17'(sgc_pkg::FREQ_ONE - thr_strong - 1 + $urandom_range(0, 2));
      3: return 17'(sgc_pkg::FREQ_ONE - thr_weak - 1 + $urandom_range(0, 2));
      4: begin
        case ($urandom_range(0, 3))
          0: return 17'd0;
          1: return sgc_pkg::FREQ_ONE;
          2: return FREQ_MAX;
          default: return FREQ_HALF;
        endcase
      end
      7: return 17'($urandom_range(0, FREQ_MAX));
      default: return 17'($urandom_range(0, sgc_pkg::FREQ_ONE));
    endcase
  endfunction

  function automatic logic [7:0] pick_allele();
    string pool;
    pool = "ACGTacgt";
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Mode 0 and 1 keep one base kind, 2 mixes kinds, 3 is mostly unknown
  function automatic logic [7:0] pick_base(int mode, logic [7:0] lead);
    string unk, pool;
    int r;
    unk = ".nN";
    pool = "ACGTacgt";
    r = $urandom_range(0, 99);
    if (r < 3) return 8'($urandom_range(0, 255));
    if (mode == 3 || r < 25) return unk[$urandom_range(0, 2)];
    if (mode < 2) return r[0] ? lead : to_lower(lead);
    return pool[$urandom_range(0, 7)];
  endfunction

  // Queue random sites until about `target` meaningful items are pending
  function automatic void queue_traffic(int target);
    string lead_pool;
    int counted, pick, len, mode;
    logic [7:0] lead;
    sgc_pkg::in_t d;
    lead_pool = "ACGT";
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_poly(pick_freq(), pick_freq(), pick_allele(), pick_allele());
        counted++;
      end else if (pick < 85) begin
        // a plain site; the top few are left open and get cut off
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(130, 300) : $urandom_range(1, 6);
        mode = $urandom_range(0, 3);
        lead = lead_pool[$urandom_range(0, 3)];
        for (int k = 0; k < len; k++)
          push_pair(pick_base(mode, lead), pick_base(mode, lead), k == len - 1 && pick < 80);
        counted += len;
      end else if (pick < 90) begin
        push_kind(sgc_pkg::REQ_END);
        counted++;
      end else if (pick < 95) begin
        push_kind(REQ_NONE);
      end else begin
        d = noise_item();
        site_feed.push_back(d);
        if (d.req_type != REQ_NONE) counted++;
      end
    end
  endfunction

  // Hold until every item is taken and every call is back, then let the pipe empty
  task automatic drain();
    while (site_feed.size() != 0 || calls_due.size() != 0 || in_valid) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [16:0] s, logic [16:0] w);
    thr_strong = s;
    thr_weak = w;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sgc_pkg::CFG_STRONG;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= sgc_pkg::CFG_WEAK;
    cfg_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [16:0] s, logic [16:0] w, int n, int gp, int sp);
    write_thresholds(s, w);
    gap_pct = gp;
    stall_pct = sp;
    queue_traffic(n);
    drain();
  endtask

  // Sender: predict on each transfer, then hold, idle or present the next item
  always @(posedge clk) begin : feed
    sgc_pkg::out_t due;
    bit            has_call;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        has_call = predict_call(in_data, due);
        if (has_call) calls_due.push_back(due);
        void'(site_feed.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (site_feed.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (site_feed.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= site_feed[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer against the oldest owed call
  always @(posedge clk) begin : watch
    sgc_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (calls_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result: %s", show_result(out_data));
        end else begin
          want = calls_due.pop_front();
          if (out_data !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch expected: %s", show_result(want));
              $display("mismatch actual:   %s", show_result(out_data));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [16:0] s, w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sites at the reset thresholds
    push_poly(sgc_pkg::FREQ_ONE, 17'd0, "a", "G");
    push_poly(FREQ_MAX, 17'd0, "A", "c");
    push_poly(17'd62259, 17'd52429, "t", "g");
    push_poly(17'd62258, 17'd52428, "C", "a");
    push_poly(17'd3277, 17'd13107, "c", "a");
    push_poly(17'd3278, 17'd13108, "g", "T");
    push_poly(FREQ_HALF, 17'd0, 8'h00, 8'hFF);
    push_poly(sgc_pkg::FREQ_ONE, sgc_pkg::FREQ_ONE, "[", "{");
    push_pair("A", "a", 1'b1);
    push_pair("c", "G", 1'b0);
    push_pair("N", ".", 1'b1);
    push_pair("n", ".", 1'b1);
    push_pair("t", "Z", 1'b1);
    // open plain site cut off by a polymorphic site
    push_pair("G", "G", 1'b0);
    push_poly(17'd0, sgc_pkg::FREQ_ONE, "T", "A");
    // an ignored request does not break a plain site
    push_pair("G", "G", 1'b0);
    push_kind(REQ_NONE);
    push_pair("T", "t", 1'b1);
    push_pair(8'hFF, 8'h00, 1'b1);
    push_kind(sgc_pkg::REQ_END);
    push_pair("g", "g", 1'b0);
    push_kind(sgc_pkg::REQ_END);
    push_kind(sgc_pkg::REQ_END);
    drain();

    // Threshold extremes, then random settings
    run_phase(sgc_pkg::FREQ_ONE, sgc_pkg::FREQ_ONE, 200, 8, 8);
    run_phase(17'd32768, 17'd32768, 200, 0, 0);
    run_phase(FREQ_MAX, FREQ_MAX, 200, 2, 10);
    run_phase(17'd0, FREQ_MAX, 200, 10, 2);
    repeat (4) begin
      s = 17'($urandom_range(32768, sgc_pkg::FREQ_ONE));
      w = 17'($urandom_range(32768, s));
      run_phase(s, w, 200, $urandom_range(0, 10), $urandom_range(0, 10));
    end
    run_phase(17'($urandom_range(0, FREQ_MAX)), 17'($urandom_range(0, FREQ_MAX)), 200, 5, 5);

    // Last part, no idling: mixed traffic back to back
    write_thresholds(sgc_pkg::STRONG_RESET, sgc_pkg::WEAK_RESET);
    gap_pct = 0;
    stall_pct = 0;
    queue_traffic(200);
    push_kind(sgc_pkg::REQ_END);
    drain();

    if (mismatch_cnt == 0 && calls_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
